/* rtl/eavr_pkg.sv */
// eavr_pkg: shared widths, defaults and the quarter-wave sine coefficients
// for the euler angle vector rotation unit
// no dependencies
package eavr_pkg;

  localparam int COORD_W = 32;
  localparam int ANG_W   = 16;
  localparam int TRIG_FRAC_BITS_DEF = 16;
  localparam int NUM_TRIG = 6;

  localparam logic [14:0] QUARTER = 15'd16384;

  // odd polynomial of the first-quadrant sine, Q30, highest order last
  localparam logic [30:0] COEF [0:6] = '{
    31'd1686629713, 31'd693598668, 31'd85569303, 31'd5026996,
    31'd172272, 31'd3864, 31'd61
  };

endpackage

/* rtl/eavr_in_if.sv */
// eavr_in_if: request channel carrying a point and three binary angles
// depends on eavr_pkg
interface eavr_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [eavr_pkg::COORD_W-1:0]      x_in;
  logic signed [eavr_pkg::COORD_W-1:0]      y_in;
  logic signed [eavr_pkg::COORD_W-1:0]      z_in;
  logic        [eavr_pkg::ANG_W-1:0]        angle_a;
  logic        [eavr_pkg::ANG_W-1:0]        angle_b;
  logic        [eavr_pkg::ANG_W-1:0]        angle_c;

  modport source (output valid, x_in, y_in, z_in, angle_a, angle_b, angle_c, input ready);
  modport sink   (input valid, x_in, y_in, z_in, angle_a, angle_b, angle_c, output ready);
endinterface

/* rtl/eavr_out_if.sv */
// eavr_out_if: result channel carrying the rotated point
// depends on eavr_pkg
interface eavr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [eavr_pkg::COORD_W-1:0] x_out;
  logic signed [eavr_pkg::COORD_W-1:0] y_out;
  logic signed [eavr_pkg::COORD_W-1:0] z_out;

  modport source (output valid, x_out, y_out, z_out, input ready);
  modport sink   (input valid, x_out, y_out, z_out, output ready);
endinterface

/* rtl/euler_angle_vector_rotation_unit.sv */
// euler_angle_vector_rotation_unit: pipelined xyz euler rotation of a q16.16 point
// depends on eavr_pkg, eavr_in_if, eavr_out_if
//
//  channel   dir  handshake        payload
//  in_ch     in   valid / ready    x_in y_in z_in (q16.16), angle_a/b/c (65536 per turn)
//  out_ch    out  valid / ready    x_out y_out z_out (q16.16, saturated)
//
// one request per cycle sustained while no result is held on out_ch
// stages: angle fold, square, six horner steps, final sine product, q-format,
//   two matrix product stages, point product, sum round and saturate
// rst_n synchronous: clears the stage valid bits only
// a held result freezes the whole pipeline; in_ch.ready follows the last stage
module euler_angle_vector_rotation_unit #(
  parameter int TRIG_FRAC_BITS = eavr_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  eavr_in_if.sink     in_ch,
  eavr_out_if.source  out_ch
);

  localparam int F   = TRIG_FRAC_BITS;
  localparam int SW  = F + 2;          // sine / cosine width, signed
  localparam int PW  = 2 * SW;         // raw product of two trig values
  localparam int MW  = F + 3;          // matrix entry width
  localparam int XW  = MW + eavr_pkg::COORD_W;  // entry times coordinate
  localparam int AW  = XW + 2;         // row sum
  localparam int VW  = AW - F;         // row sum after scaling
  localparam int NT  = eavr_pkg::NUM_TRIG;
  localparam int NST = 14;
  localparam int NPT = 12;             // stages that carry the point

  // stage valids and global advance
  logic [NST-1:0] vld_r;
  logic           adv;

  assign adv         = !vld_r[NST-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_ch.valid};
    end
  end

  // point carried alongside the trig work
  logic signed [eavr_pkg::COORD_W-1:0] px_r [NPT];
  logic signed [eavr_pkg::COORD_W-1:0] py_r [NPT];
  logic signed [eavr_pkg::COORD_W-1:0] pz_r [NPT];

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r[0] <= in_ch.x_in;
      py_r[0] <= in_ch.y_in;
      pz_r[0] <= in_ch.z_in;
      for (int i = 1; i < NPT; i++) begin
        px_r[i] <= px_r[i-1];
        py_r[i] <= py_r[i-1];
        pz_r[i] <= pz_r[i-1];
      end
    end
  end

  // stage 1: fold each angle into a quarter-wave offset and a sign
  // channels: sin a, cos a, sin b, cos b, sin c, cos c
  logic [eavr_pkg::ANG_W-1:0] ang [NT];
  logic [14:0]                t_r   [NT];
  logic                       neg_r [NT];

  always_comb begin
    ang[0] = in_ch.angle_a;
    ang[1] = in_ch.angle_a + eavr_pkg::ANG_W'(eavr_pkg::QUARTER);
    ang[2] = in_ch.angle_b;
    ang[3] = in_ch.angle_b + eavr_pkg::ANG_W'(eavr_pkg::QUARTER);
    ang[4] = in_ch.angle_c;
    ang[5] = in_ch.angle_c + eavr_pkg::ANG_W'(eavr_pkg::QUARTER);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < NT; c++) begin
        t_r[c]   <= ang[c][14] ? (eavr_pkg::QUARTER - {1'b0, ang[c][13:0]})
                               : {1'b0, ang[c][13:0]};
        neg_r[c] <= ang[c][15];
      end
    end
  end

  // horner stages: index 0 squares the offset, 1..6 each take one coefficient
  logic [30:0] hp_r   [7][NT];
  logic [30:0] hu2_r  [7][NT];
  logic [14:0] ht_r   [7][NT];
  logic        hneg_r [7][NT];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < NT; c++) begin
        hp_r[0][c]   <= eavr_pkg::COEF[6];
        hu2_r[0][c]  <= (31'(t_r[c]) * 31'(t_r[c])) << 2;
        ht_r[0][c]   <= t_r[c];
        hneg_r[0][c] <= neg_r[c];
      end
    end
  end

  for (genvar h = 1; h < 7; h++) begin : g_horner
    logic [61:0] prod [NT];
    logic [30:0] dd   [NT];

    always_comb begin
      for (int c = 0; c < NT; c++) begin
        prod[c] = 62'(hp_r[h-1][c]) * 62'(hu2_r[h-1][c]);
        dd[c]   = prod[c][60:30];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int c = 0; c < NT; c++) begin
          hp_r[h][c]   <= (eavr_pkg::COEF[6-h] > dd[c]) ? eavr_pkg::COEF[6-h] - dd[c]
                                                        : '0;
          hu2_r[h][c]  <= hu2_r[h-1][c];
          ht_r[h][c]   <= ht_r[h-1][c];
          hneg_r[h][c] <= hneg_r[h-1][c];
        end
      end
    end
  end

  // stage 9: multiply by the offset once more, clamp to one
  logic [61:0] qprod [NT];
  logic [31:0] qraw  [NT];
  logic [30:0] q_r    [NT];
  logic        qneg_r [NT];

  always_comb begin
    for (int c = 0; c < NT; c++) begin
      qprod[c] = 62'(hp_r[6][c]) * 62'({ht_r[6][c], 16'd0});
      qraw[c]  = qprod[c][61:30];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < NT; c++) begin
        q_r[c]    <= (qraw[c] > 32'(1 << 30)) ? 31'(1 << 30) : qraw[c][30:0];
        qneg_r[c] <= hneg_r[6][c];
      end
    end
  end

  // stage 10: q30 to trig fraction format, rounded, clamped, signed
  logic [31:0]          qf  [NT];
  logic [SW-1:0]        mag [NT];
  logic signed [SW-1:0] sc_r [NT];

  always_comb begin
    for (int c = 0; c < NT; c++) begin
      qf[c]  = ({1'b0, q_r[c]} + 32'(1 << (29 - F))) >> (30 - F);
      mag[c] = (qf[c] > 32'(1 << F)) ? SW'(1 << F) : SW'(qf[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < NT; c++) begin
        sc_r[c] <= qneg_r[c] ? -$signed(mag[c]) : $signed(mag[c]);
      end
    end
  end

  function automatic logic signed [SW-1:0] rmul(input logic signed [SW-1:0] a,
                                                input logic signed [SW-1:0] b);
    logic signed [PW-1:0] pr;
    pr = PW'(a) * PW'(b);
    pr = pr + PW'(1 << (F - 1));
    return SW'(pr >>> F);
  endfunction

  // stage 11: first rank of trig products
  logic signed [SW-1:0] t1_r, t2_r, m00_r, m01_r, m02_r, m12_r, m22_r;
  logic signed [SW-1:0] casg_r, cacg_r, sasg_r, cgsa_r, cg1_r, sg1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r   <= rmul(sc_r[0], sc_r[2]);
      t2_r   <= rmul(sc_r[1], sc_r[2]);
      m00_r  <= rmul(sc_r[3], sc_r[5]);
      m01_r  <= -rmul(sc_r[3], sc_r[4]);
      m02_r  <= sc_r[2];
      m12_r  <= -rmul(sc_r[3], sc_r[0]);
      m22_r  <= rmul(sc_r[1], sc_r[3]);
      casg_r <= rmul(sc_r[1], sc_r[4]);
      cacg_r <= rmul(sc_r[1], sc_r[5]);
      sasg_r <= rmul(sc_r[0], sc_r[4]);
      cgsa_r <= rmul(sc_r[5], sc_r[0]);
      cg1_r  <= sc_r[5];
      sg1_r  <= sc_r[4];
    end
  end

  // stage 12: second rank, full matrix in row-major order
  logic signed [MW-1:0] mat_r [9];

  always_ff @(posedge clk) begin
    if (adv) begin
      mat_r[0] <= MW'(m00_r);
      mat_r[1] <= MW'(m01_r);
      mat_r[2] <= MW'(m02_r);
      mat_r[3] <= MW'(casg_r) + MW'(rmul(cg1_r, t1_r));
      mat_r[4] <= MW'(cacg_r) - MW'(rmul(t1_r, sg1_r));
      mat_r[5] <= MW'(m12_r);
      mat_r[6] <= MW'(sasg_r) - MW'(rmul(cg1_r, t2_r));
      mat_r[7] <= MW'(cgsa_r) + MW'(rmul(t2_r, sg1_r));
      mat_r[8] <= MW'(m22_r);
    end
  end

  // stage 13: nine entry-by-coordinate products
  logic signed [XW-1:0] xp_r [9];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        xp_r[3*r]   <= XW'(mat_r[3*r])   * XW'(px_r[NPT-1]);
        xp_r[3*r+1] <= XW'(mat_r[3*r+1]) * XW'(py_r[NPT-1]);
        xp_r[3*r+2] <= XW'(mat_r[3*r+2]) * XW'(pz_r[NPT-1]);
      end
    end
  end

  // stage 14: row sums, round half up, saturate to q16.16
  logic signed [AW-1:0] acc [3];
  logic signed [VW-1:0] sv  [3];
  logic signed [eavr_pkg::COORD_W-1:0] res [3];
  logic signed [eavr_pkg::COORD_W-1:0] res_r [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = AW'(xp_r[3*r]) + AW'(xp_r[3*r+1]) + AW'(xp_r[3*r+2])
             + AW'(1 << (F - 1));
      sv[r]  = VW'(acc[r] >>> F);
      if (sv[r][VW-1:eavr_pkg::COORD_W-1] == '0 || sv[r][VW-1:eavr_pkg::COORD_W-1] == '1) begin
        res[r] = sv[r][eavr_pkg::COORD_W-1:0];
      end else begin
        res[r] = sv[r][VW-1] ? {1'b1, {(eavr_pkg::COORD_W-1){1'b0}}}
                             : {1'b0, {(eavr_pkg::COORD_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        res_r[r] <= res[r];
      end
    end
  end

  assign out_ch.valid = vld_r[NST-1];
  assign out_ch.x_out = res_r[0];
  assign out_ch.y_out = res_r[1];
  assign out_ch.z_out = res_r[2];

endmodule

/* rtl/eavr_chk.sv */
// eavr_chk: port-level checks for the euler angle vector rotation unit, bound to the top
// depends on eavr_pkg and euler_angle_vector_rotation_unit
module eavr_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [eavr_pkg::COORD_W-1:0] x_out,
  input logic signed [eavr_pkg::COORD_W-1:0] y_out,
  input logic signed [eavr_pkg::COORD_W-1:0] z_out
);

  // a held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(x_out) && $stable(y_out) && $stable(z_out))
    else $error("held result changed");

  // pipeline accepts whenever the output stage is free
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("request refused with free output");

  // a stalled output freezes intake
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken during stall");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind euler_angle_vector_rotation_unit eavr_chk u_eavr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .x_out     (out_ch.x_out),
  .y_out     (out_ch.y_out),
  .z_out     (out_ch.z_out)
);
